// ===== hdl/ptt_pkg.sv =====
// Shared types, codes and constants of the periodic task table.
package ptt_pkg;

   localparam int TABLE_SLOTS_DEFAULT = 16;
   localparam int MAX_RESULTS = 16;
   localparam int TPS_W = 10;
   localparam int INTERVAL_W = 26;
   localparam logic [TPS_W-1:0] TPS_RESET = 10'd100;

   localparam logic [1:0] REQ_ADD = 2'd0;
   localparam logic [1:0] REQ_REMOVE = 2'd1;
   localparam logic [1:0] REQ_TICK = 2'd2;

   localparam logic [2:0] KIND_ADDED = 3'd0;
   localparam logic [2:0] KIND_FULL = 3'd1;
   localparam logic [2:0] KIND_REMOVED = 3'd2;
   localparam logic [2:0] KIND_IGNORED = 3'd3;
   localparam logic [2:0] KIND_FIRED = 3'd4;
   localparam logic [2:0] KIND_NONE = 3'd5;

   typedef struct packed {
      logic [1:0] req_type;
      logic [15:0] period_secs;
      logic [7:0] task_index;
      logic signed [31:0] tick_now;
   } req_word_type;

   typedef struct packed {
      logic [2:0] result_kind;
      logic [3:0] slot_index;
      logic [31:0] run_count;
      logic last;
   } rsp_word_type;

   typedef struct packed {
      logic valid;
      rsp_word_type word;
   } emit_type;

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_ADD = 6'b000010,
      ST_REMOVE = 6'b000100,
      ST_READ = 6'b001000,
      ST_EVAL = 6'b010000,
      ST_FLUSH = 6'b100000
   } seq_state_type;

   typedef enum logic {
      ALU_SCALE = 1'b0,
      ALU_CHECK = 1'b1
   } alu_op_type;

   typedef struct packed {
      alu_op_type op;
      logic [15:0] isec;
      logic [TPS_W-1:0] tps;
      logic [31:0] now;
      logic [31:0] prev_tick;
      logic [INTERVAL_W-1:0] interval;
      logic [31:0] runs;
   } alu_in_type;

   typedef struct packed {
      logic [INTERVAL_W-1:0] product;
      logic fire;
      logic [31:0] runs_next;
   } alu_out_type;

endpackage

// ===== hdl/ptt_alu.sv =====
// Shared arithmetic unit: interval scaling and the per-slot due check.
module ptt_alu (
   input ptt_pkg::alu_in_type alu_in,
   output ptt_pkg::alu_out_type alu_out
);

   logic [31:0] diff;

   assign diff = alu_in.now - alu_in.prev_tick;

   always_comb begin
      alu_out = '0;
      case (alu_in.op)
         ptt_pkg::ALU_SCALE: begin
            alu_out.product = ptt_pkg::INTERVAL_W'(
               {10'b0, alu_in.isec} * {16'b0, alu_in.tps});
         end
         ptt_pkg::ALU_CHECK: begin
            // A negative wrapped difference never fires.
            alu_out.fire = !diff[31] && (diff >= {6'b0, alu_in.interval});
            alu_out.runs_next = alu_in.runs + 32'd1;
         end
         default: begin
            alu_out = '0;
         end
      endcase
   end

endmodule

// ===== hdl/ptt_seq.sv =====
// Sequencer with the slot store: add, remove and the slot-by-slot tick scan.
module ptt_seq #(
   parameter int TABLE_SLOTS = ptt_pkg::TABLE_SLOTS_DEFAULT
) (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input ptt_pkg::req_word_type req_word,
   output logic req_stall,
   input logic [ptt_pkg::TPS_W-1:0] tps,
   input logic out_free,
   output ptt_pkg::emit_type emit
);

   localparam int SW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
   localparam int UW = $clog2(TABLE_SLOTS + 1);
   localparam int CW = $clog2(ptt_pkg::MAX_RESULTS + 1);
   localparam int IW = ptt_pkg::INTERVAL_W;

   ptt_pkg::seq_state_type state_ff, state_in;
   ptt_pkg::req_word_type req_ff, req_in;
   logic [UW-1:0] used_ff, used_in;
   logic [TABLE_SLOTS-1:0] active_ff, active_in;
   logic [SW-1:0] scan_ff, scan_in;
   logic [CW-1:0] count_ff, count_in;
   logic pend_valid_ff, pend_valid_in;
   logic [SW-1:0] pend_slot_ff, pend_slot_in;
   logic [31:0] pend_runs_ff, pend_runs_in;

   logic [IW-1:0] interval_mem [TABLE_SLOTS];
   logic [31:0] last_mem [TABLE_SLOTS];
   logic [31:0] runs_mem [TABLE_SLOTS];
   logic [IW-1:0] rd_interval_ff;
   logic [31:0] rd_last_ff;
   logic [31:0] rd_runs_ff;

   logic int_we;
   logic run_we;
   logic [SW-1:0] wr_addr;
   logic [IW-1:0] int_wdata;
   logic [31:0] last_wdata;
   logic [31:0] runs_wdata;
   logic advance;

   ptt_pkg::alu_in_type alu_in;
   ptt_pkg::alu_out_type alu_out;

   always_comb begin
      alu_in.op = (state_ff == ptt_pkg::ST_ADD) ? ptt_pkg::ALU_SCALE : ptt_pkg::ALU_CHECK;
      alu_in.isec = req_ff.period_secs;
      alu_in.tps = tps;
      alu_in.now = unsigned'(req_ff.tick_now);
      alu_in.prev_tick = rd_last_ff;
      alu_in.interval = rd_interval_ff;
      alu_in.runs = rd_runs_ff;
   end

   ptt_alu u_alu (
      .alu_in(alu_in),
      .alu_out(alu_out)
   );

   assign req_stall = (state_ff != ptt_pkg::ST_IDLE);

   always_comb begin
      state_in = state_ff;
      req_in = req_ff;
      used_in = used_ff;
      active_in = active_ff;
      scan_in = scan_ff;
      count_in = count_ff;
      pend_valid_in = pend_valid_ff;
      pend_slot_in = pend_slot_ff;
      pend_runs_in = pend_runs_ff;
      emit = '0;
      int_we = 1'b0;
      run_we = 1'b0;
      wr_addr = scan_ff;
      int_wdata = alu_out.product;
      last_wdata = unsigned'(req_ff.tick_now);
      runs_wdata = alu_out.runs_next;
      advance = 1'b1;

      case (state_ff)
         ptt_pkg::ST_IDLE: begin
            if (req_valid) begin
               req_in = req_word;
               case (req_word.req_type)
                  ptt_pkg::REQ_ADD: begin
                     state_in = ptt_pkg::ST_ADD;
                  end
                  ptt_pkg::REQ_REMOVE: begin
                     state_in = ptt_pkg::ST_REMOVE;
                  end
                  ptt_pkg::REQ_TICK: begin
                     scan_in = '0;
                     count_in = '0;
                     pend_valid_in = 1'b0;
                     state_in = (used_ff == '0) ? ptt_pkg::ST_FLUSH : ptt_pkg::ST_READ;
                  end
                  default: begin
                     state_in = ptt_pkg::ST_IDLE;
                  end
               endcase
            end
         end
         ptt_pkg::ST_ADD: begin
            if (out_free) begin
               state_in = ptt_pkg::ST_IDLE;
               emit.valid = 1'b1;
               emit.word.last = 1'b1;
               if (used_ff >= UW'(TABLE_SLOTS)) begin
                  emit.word.result_kind = ptt_pkg::KIND_FULL;
               end else begin
                  int_we = 1'b1;
                  run_we = 1'b1;
                  wr_addr = used_ff[SW-1:0];
                  last_wdata = '0;
                  runs_wdata = '0;
                  active_in[used_ff[SW-1:0]] = 1'b1;
                  used_in = used_ff + UW'(1);
                  emit.word.result_kind = ptt_pkg::KIND_ADDED;
                  emit.word.slot_index = 4'(used_ff);
               end
            end
         end
         ptt_pkg::ST_REMOVE: begin
            if (out_free) begin
               state_in = ptt_pkg::ST_IDLE;
               emit.valid = 1'b1;
               emit.word.last = 1'b1;
               if (req_ff.task_index >= 8'(used_ff)) begin
                  emit.word.result_kind = ptt_pkg::KIND_IGNORED;
               end else begin
                  active_in[req_ff.task_index[SW-1:0]] = 1'b0;
                  emit.word.result_kind = ptt_pkg::KIND_REMOVED;
                  emit.word.slot_index = 4'(req_ff.task_index);
               end
            end
         end
         ptt_pkg::ST_READ: begin
            state_in = ptt_pkg::ST_EVAL;
         end
         ptt_pkg::ST_EVAL: begin
            if (active_ff[scan_ff] && alu_out.fire) begin
               if ((count_ff < CW'(ptt_pkg::MAX_RESULTS)) && pend_valid_ff && !out_free) begin
                  advance = 1'b0;
               end else begin
                  run_we = 1'b1;
                  if (count_ff < CW'(ptt_pkg::MAX_RESULTS)) begin
                     // The held word is known not to be the final one now.
                     if (pend_valid_ff) begin
                        emit.valid = 1'b1;
                        emit.word.result_kind = ptt_pkg::KIND_FIRED;
                        emit.word.slot_index = 4'(pend_slot_ff);
                        emit.word.run_count = pend_runs_ff;
                     end
                     pend_valid_in = 1'b1;
                     pend_slot_in = scan_ff;
                     pend_runs_in = alu_out.runs_next;
                     count_in = count_ff + CW'(1);
                  end
               end
            end
            if (advance) begin
               if (UW'(scan_ff) + UW'(1) == used_ff) begin
                  state_in = ptt_pkg::ST_FLUSH;
               end else begin
                  scan_in = scan_ff + SW'(1);
                  state_in = ptt_pkg::ST_READ;
               end
            end
         end
         ptt_pkg::ST_FLUSH: begin
            if (out_free) begin
               state_in = ptt_pkg::ST_IDLE;
               emit.valid = 1'b1;
               emit.word.last = 1'b1;
               if (pend_valid_ff) begin
                  emit.word.result_kind = ptt_pkg::KIND_FIRED;
                  emit.word.slot_index = 4'(pend_slot_ff);
                  emit.word.run_count = pend_runs_ff;
               end else begin
                  emit.word.result_kind = ptt_pkg::KIND_NONE;
               end
            end
         end
         default: begin
            state_in = ptt_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ptt_pkg::ST_IDLE;
         used_ff <= '0;
         active_ff <= '0;
         pend_valid_ff <= 1'b0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         used_ff <= used_in;
         active_ff <= active_in;
         pend_valid_ff <= pend_valid_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      scan_ff <= scan_in;
      pend_slot_ff <= pend_slot_in;
      pend_runs_ff <= pend_runs_in;
   end

   always_ff @(posedge clock) begin
      if (int_we) begin
         interval_mem[wr_addr] <= int_wdata;
      end
      if (run_we) begin
         last_mem[wr_addr] <= last_wdata;
         runs_mem[wr_addr] <= runs_wdata;
      end
      if (state_ff == ptt_pkg::ST_READ) begin
         rd_interval_ff <= interval_mem[scan_ff];
         rd_last_ff <= last_mem[scan_ff];
         rd_runs_ff <= runs_mem[scan_ff];
      end
   end

endmodule

// ===== hdl/periodic_task_table_core.sv =====
// Top level of the periodic task table: configuration, sequencer and result register.
//
// The block keeps a table of TABLE_SLOTS periodic tasks. An add word scales
// its interval in seconds by the ticks-per-second register and fills the
// next unused slot; slots are never reused, so once every slot has been
// handed out each further add is answered with table full. A remove word
// marks a slot inactive. A tick word carries the current tick count and is
// checked against every used, active slot in ascending order; each slot that
// is due yields one task-fired result word, up to MAX_RESULTS per tick, and a
// tick that fires nothing yields a single none-fired word. The last result
// word of every request has its last flag set. Sequence: an add or a remove
// passes through its own state, which loads the result word into the output
// register once that register is free; a tick visits each used slot in a
// read state and then an evaluate state, since the single slot store read
// port and the shared compare unit serve one slot at a time, and ends in a
// flush state that loads its final word. The undefined request code is
// taken and gives no result. The block takes one request at a time and holds
// req_stall high until the request's final result word has been loaded into
// the output register; a stalled result side holds the scan where it stands.
module periodic_task_table_core #(
   parameter int TABLE_SLOTS = ptt_pkg::TABLE_SLOTS_DEFAULT
) (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_stall,
   input ptt_pkg::req_word_type req_word,
   output logic rsp_valid,
   input logic rsp_stall,
   output ptt_pkg::rsp_word_type rsp_word,
   input logic csr_wr_en,
   input logic [ptt_pkg::TPS_W-1:0] csr_wr_data
);

   // Ticks per second; it only affects tasks added after it is written.
   logic [ptt_pkg::TPS_W-1:0] tps_ff;

   // Output register: a result word waits here while the next one is formed.
   logic rsp_valid_ff;
   ptt_pkg::rsp_word_type rsp_word_ff;
   logic out_free;
   ptt_pkg::emit_type emit;

   // The sequencer may load a new word when the register is empty or is
   // being emptied in this very cycle.
   assign out_free = !rsp_valid_ff || !rsp_stall;

   ptt_seq #(
      .TABLE_SLOTS(TABLE_SLOTS)
   ) u_seq (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_word(req_word),
      .req_stall(req_stall),
      .tps(tps_ff),
      .out_free(out_free),
      .emit(emit)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         tps_ff <= ptt_pkg::TPS_RESET;
      end else if (csr_wr_en) begin
         tps_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit.valid) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit.valid) begin
         rsp_word_ff <= emit.word;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word = rsp_word_ff;

endmodule
